>>> hdl/distance_lod_child_select_assert.svh
// assertion macros for the level-of-detail child selector
`ifndef DISTANCE_LOD_CHILD_SELECT_ASSERT_SVH
`define DISTANCE_LOD_CHILD_SELECT_ASSERT_SVH

// same-cycle implication
`define DLCS_ASSERT_NOW(lbl, clk, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define DLCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/dlcs_pkg.sv
// shared widths, types and constants of the level-of-detail child selector
`timescale 1ns / 1ps
package dlcs_pkg;
	localparam int COORD_BITS   = 16;
	localparam int MAX_CHILDREN = 256;
	localparam int LIMIT_W      = 17;
	localparam int COUNT_W      = 9;
	localparam int IDX_W        = 8;
	localparam int CFG_IDX_W    = 1;
	localparam int DIFF_W       = COORD_BITS + 1;
	localparam int SQ_W         = 2 * DIFF_W;
	localparam int RAD_W        = 2 * (DIFF_W + 1);
	localparam int ROOT_W       = RAD_W / 2;
	localparam int REM_W        = ROOT_W + 2;
	localparam int DEN_W        = LIMIT_W;
	localparam int DREM_W       = DEN_W + 1;
	localparam int NUM_W        = IDX_W + LIMIT_W;

	localparam logic [CFG_IDX_W-1:0] REG_NEAR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAR  = 1'd1;

	localparam logic [LIMIT_W-1:0] NEAR_RESET = 17'd10;
	localparam logic [LIMIT_W-1:0] FAR_RESET  = 17'd100;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [IDX_W-1:0]  top;
		logic              force0;
	} sqrt_item_t;

	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic [IDX_W-1:0]  low;
		logic [IDX_W-1:0]  quot;
		logic [DEN_W-1:0]  den;
		logic [IDX_W-1:0]  idx;
		logic              done;
	} div_item_t;
endpackage

>>> hdl/dlcs_sqrt_cell.sv
// one digit step of the pipelined integer square root
`timescale 1ns / 1ps
module dlcs_sqrt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                v_i,
	input  dlcs_pkg::sqrt_item_t d_i,
	input  logic                adv_i,
	output logic                rdy_o,
	output logic                v_o,
	output dlcs_pkg::sqrt_item_t d_o
);
	logic                        v_q;
	dlcs_pkg::sqrt_item_t        d_q;
	logic [dlcs_pkg::REM_W-1:0]  rem_sh;
	logic [dlcs_pkg::REM_W-1:0]  trial;
	logic                        ge;
	dlcs_pkg::sqrt_item_t        nxt;

	assign rdy_o = !v_q || adv_i;
	assign v_o   = v_q;
	assign d_o   = d_q;

	always_comb begin
		rem_sh = {d_i.rem[dlcs_pkg::REM_W-3:0], d_i.rad[dlcs_pkg::RAD_W-1 -: 2]};
		trial  = {d_i.root, 2'b01};
		ge     = rem_sh >= trial;
		nxt        = d_i;
		nxt.rad    = {d_i.rad[dlcs_pkg::RAD_W-3:0], 2'b00};
		nxt.rem    = ge ? rem_sh - trial : rem_sh;
		nxt.root   = {d_i.root[dlcs_pkg::ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy_o) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && v_i) begin
			d_q <= nxt;
		end
	end
endmodule

>>> hdl/dlcs_div_cell.sv
// one quotient bit of the pipelined restoring divider
`timescale 1ns / 1ps
module dlcs_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               v_i,
	input  dlcs_pkg::div_item_t d_i,
	input  logic               adv_i,
	output logic               rdy_o,
	output logic               v_o,
	output dlcs_pkg::div_item_t d_o
);
	logic                        v_q;
	dlcs_pkg::div_item_t         d_q;
	logic [dlcs_pkg::DREM_W-1:0] rem_sh;
	logic [dlcs_pkg::DREM_W-1:0] den_x;
	logic                        ge;
	dlcs_pkg::div_item_t         nxt;

	assign rdy_o = !v_q || adv_i;
	assign v_o   = v_q;
	assign d_o   = d_q;

	always_comb begin
		rem_sh = {d_i.rem[dlcs_pkg::DEN_W-1:0], d_i.low[dlcs_pkg::IDX_W-1]};
		den_x  = {1'b0, d_i.den};
		ge     = rem_sh >= den_x;
		nxt      = d_i;
		nxt.rem  = ge ? rem_sh - den_x : rem_sh;
		nxt.low  = {d_i.low[dlcs_pkg::IDX_W-2:0], 1'b0};
		nxt.quot = {d_i.quot[dlcs_pkg::IDX_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy_o) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && v_i) begin
			d_q <= nxt;
		end
	end
endmodule

>>> hdl/distance_lod_child_select.sv
// top level of the distance based level-of-detail child selector
// pipeline: 28 register stages (squares, 18 root cells, limit compare, 8 divider
// cells, the last one being the output register)
// throughput: one item per cycle while out_stall is low; each stage moves on when
// it is empty or its successor moves, so bubbles collapse behind a stalled output
// reset: clears all valid bits and loads near limit 10 and far limit 100
`timescale 1ns / 1ps
module distance_lod_child_select (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [dlcs_pkg::COORD_BITS-1:0] node_x,
	input  logic signed [dlcs_pkg::COORD_BITS-1:0] node_y,
	input  logic signed [dlcs_pkg::COORD_BITS-1:0] node_z,
	input  logic signed [dlcs_pkg::COORD_BITS-1:0] camera_x,
	input  logic signed [dlcs_pkg::COORD_BITS-1:0] camera_y,
	input  logic signed [dlcs_pkg::COORD_BITS-1:0] camera_z,
	input  logic                                   camera_present,
	input  logic [dlcs_pkg::COUNT_W-1:0]           child_count,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [dlcs_pkg::IDX_W-1:0]             child_index,
	input  logic                                   cfg_we,
	input  logic [dlcs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dlcs_pkg::LIMIT_W-1:0]           cfg_data
);
	localparam int NSQ = dlcs_pkg::ROOT_W;
	localparam int NDV = dlcs_pkg::IDX_W;

	logic [dlcs_pkg::LIMIT_W-1:0] near_q, far_q;

	// stage 1: squared differences
	logic                          v_s1;
	logic [dlcs_pkg::SQ_W-1:0]     sqx_s1, sqy_s1, sqz_s1;
	logic [dlcs_pkg::IDX_W-1:0]    top_s1;
	logic                          force_s1;
	logic                          rdy_s1;
	logic [dlcs_pkg::DIFF_W-1:0]   adx, ady, adz;
	logic [dlcs_pkg::COUNT_W-1:0]  cnt_sat;

	// square root chain
	logic                 sq_v   [NSQ+1];
	dlcs_pkg::sqrt_item_t sq_d   [NSQ+1];
	logic                 sq_rdy [NSQ+1];

	// stage 2: limit compare
	logic                 v_s2;
	dlcs_pkg::div_item_t  dv_s2;
	logic                 rdy_s2;
	dlcs_pkg::div_item_t  cls;
	logic [dlcs_pkg::ROOT_W-1:0]  dist_root;
	logic [dlcs_pkg::LIMIT_W-1:0] dmn;
	logic [dlcs_pkg::NUM_W-1:0]   num;

	// divider chain
	logic                dv_v   [NDV+1];
	dlcs_pkg::div_item_t dv_d   [NDV+1];
	logic                dv_rdy [NDV+1];

	function automatic logic [dlcs_pkg::DIFF_W-1:0] absdiff(
		input logic signed [dlcs_pkg::COORD_BITS-1:0] a,
		input logic signed [dlcs_pkg::COORD_BITS-1:0] b
	);
		logic signed [dlcs_pkg::DIFF_W-1:0] t;
		t = dlcs_pkg::DIFF_W'(a) - dlcs_pkg::DIFF_W'(b);
		return t[dlcs_pkg::DIFF_W-1] ? dlcs_pkg::DIFF_W'(-t) : dlcs_pkg::DIFF_W'(t);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= dlcs_pkg::NEAR_RESET;
			far_q  <= dlcs_pkg::FAR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dlcs_pkg::REG_NEAR: near_q <= cfg_data;
				dlcs_pkg::REG_FAR:  far_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = !rdy_s1;
	assign rdy_s1   = !v_s1 || sq_rdy[0];

	always_comb begin
		adx = absdiff(node_x, camera_x);
		ady = absdiff(node_y, camera_y);
		adz = absdiff(node_z, camera_z);
		cnt_sat = (child_count > dlcs_pkg::COUNT_W'(dlcs_pkg::MAX_CHILDREN)) ?
			dlcs_pkg::COUNT_W'(dlcs_pkg::MAX_CHILDREN) : child_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			sqx_s1   <= adx * adx;
			sqy_s1   <= ady * ady;
			sqz_s1   <= adz * adz;
			top_s1   <= dlcs_pkg::IDX_W'(cnt_sat - 1'b1);
			force_s1 <= !camera_present || (cnt_sat == '0);
		end
	end

	always_comb begin
		sq_v[0]         = v_s1;
		sq_d[0].rad     = dlcs_pkg::RAD_W'(sqx_s1) + dlcs_pkg::RAD_W'(sqy_s1)
			+ dlcs_pkg::RAD_W'(sqz_s1);
		sq_d[0].rem     = '0;
		sq_d[0].root    = '0;
		sq_d[0].top     = top_s1;
		sq_d[0].force0  = force_s1;
		sq_rdy[NSQ]     = rdy_s2;
	end

	for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
		dlcs_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_i    (sq_v[i]),
			.d_i    (sq_d[i]),
			.adv_i  (sq_rdy[i+1]),
			.rdy_o  (sq_rdy[i]),
			.v_o    (sq_v[i+1]),
			.d_o    (sq_d[i+1])
		);
	end

	// classify against the limits and set up the interpolation divide
	always_comb begin
		dist_root = sq_d[NSQ].root;
		dmn  = dlcs_pkg::LIMIT_W'(dist_root - dlcs_pkg::ROOT_W'(near_q));
		num  = dlcs_pkg::NUM_W'(sq_d[NSQ].top) * dlcs_pkg::NUM_W'(dmn);
		cls.rem  = dlcs_pkg::DREM_W'(num[dlcs_pkg::NUM_W-1:dlcs_pkg::IDX_W]);
		cls.low  = num[dlcs_pkg::IDX_W-1:0];
		cls.quot = '0;
		cls.den  = far_q - near_q;
		cls.idx  = '0;
		cls.done = 1'b1;
		if (sq_d[NSQ].force0) begin
			cls.idx = '0;
		end else if (far_q <= near_q) begin
			cls.idx = (dist_root >= dlcs_pkg::ROOT_W'(far_q)) ? sq_d[NSQ].top : '0;
		end else if (dist_root < dlcs_pkg::ROOT_W'(near_q)) begin
			cls.idx = '0;
		end else if (dist_root >= dlcs_pkg::ROOT_W'(far_q)) begin
			cls.idx = sq_d[NSQ].top;
		end else begin
			cls.done = 1'b0;
		end
	end

	assign rdy_s2 = !v_s2 || dv_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= sq_v[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && sq_v[NSQ]) begin
			dv_s2 <= cls;
		end
	end

	always_comb begin
		dv_v[0]     = v_s2;
		dv_d[0]     = dv_s2;
		dv_rdy[NDV] = !out_stall;
	end

	for (genvar j = 0; j < NDV; j++) begin : g_div
		dlcs_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_i    (dv_v[j]),
			.d_i    (dv_d[j]),
			.adv_i  (dv_rdy[j+1]),
			.rdy_o  (dv_rdy[j]),
			.v_o    (dv_v[j+1]),
			.d_o    (dv_d[j+1])
		);
	end

	assign out_valid   = dv_v[NDV];
	assign child_index = dv_d[NDV].done ? dv_d[NDV].idx : dv_d[NDV].quot;
endmodule

>>> hdl/dlcs_checker.sv
// port-level checks of the level-of-detail child selector, bound to the top
`timescale 1ns / 1ps
`include "distance_lod_child_select_assert.svh"
module dlcs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [dlcs_pkg::IDX_W-1:0]   child_index
);
	// no result shows while reset is held
	`DLCS_ASSERT_NOW(a_rst_quiet, clk, !arst_n, !out_valid)
	// input only backs up when the output is blocked
	`DLCS_ASSERT_NOW(a_stall_cause, clk, !(out_valid && out_stall), !in_stall)
	// a blocked result holds
	`DLCS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(child_index))
endmodule

bind distance_lod_child_select dlcs_checker u_dlcs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.child_index (child_index)
);
